// ===== rtl/awt_pkg.sv =====
`timescale 1ns / 1ps

package awt_pkg;

	localparam int ADDR_W = 32;
	localparam int EXT_W  = 64;
	localparam int IDX_W  = 7;
	localparam int CMD_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_FORWARD = 2'd0,
		CMD_RETURN  = 2'd1,
		CMD_WRITE   = 2'd2
	} cmd_t;

	// One item on its way down the chain of cells. The fields are shared:
	// on a write, a/b/x/idx/flag carry the new entry (internal base, size,
	// external base, index, enable); on a lookup, a is the address, and
	// b/x/idx/flag collect the offset, external base, number and hit of the
	// first covering window.
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [EXT_W-1:0]  x;
		logic [IDX_W-1:0]  idx;
		logic              flag;
	} tok_t;

endpackage

// ===== rtl/awt_cell.sv =====
`timescale 1ns / 1ps

module awt_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  awt_pkg::tok_t tok_in,
	output awt_pkg::tok_t tok_out
);
	import awt_pkg::*;

	localparam bit WRITABLE = CELL_INDEX < (1 << IDX_W);

	logic              en_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] size_q;
	logic [EXT_W-1:0]  ext_q;
	logic              valid_q;
	tok_t              data_q;

	logic              wr_here;
	logic              is_lookup;
	logic [ADDR_W:0]   upper;
	logic              covers;
	tok_t              tok_next;

	assign wr_here = WRITABLE && tok_in.valid && tok_in.cmd == CMD_WRITE &&
		tok_in.idx == IDX_W'(CELL_INDEX);
	assign is_lookup = tok_in.cmd == CMD_FORWARD || tok_in.cmd == CMD_RETURN;
	assign upper = {1'b0, base_q} + {1'b0, size_q};
	assign covers = en_q && (tok_in.a >= base_q) && ({1'b0, tok_in.a} <= upper);

	always_comb begin
		tok_next = tok_in;
		if (is_lookup && !tok_in.flag && covers) begin
			tok_next.flag = 1'b1;
			tok_next.idx  = IDX_W'(CELL_INDEX);
			tok_next.b    = tok_in.a - base_q;
			tok_next.x    = ext_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
			if (wr_here) begin
				en_q <= tok_in.flag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= tok_next;
			if (wr_here) begin
				base_q <= tok_in.a;
				size_q <= tok_in.b;
				ext_q  <= tok_in.x;
			end
		end
	end

	always_comb begin
		tok_out       = data_q;
		tok_out.valid = valid_q;
	end

endmodule

// ===== rtl/address_window_translator.sv =====
`timescale 1ns / 1ps

// Translates internal addresses through a table of NUM_WINDOWS windows held
// in a row of cells, one window per cell. Every transfer walks the row from
// window 0 upward, one cell per cycle while the result side keeps up. Each
// cell has one register, and the first one loads on the edge that takes the
// transfer. The output register that forms the external address follows the
// last cell, and the result is offered from it. A new transfer is taken every
// cycle while the result side keeps up. A write loads its entry when it
// passes its cell, so later transfers see it and earlier ones do not. Only
// windows 0 to 127 can be written; higher cells stay disabled.
module address_window_translator #(
	parameter int NUM_WINDOWS = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// address[31:0], entry_index[38:32], entry_enable[39],
	// entry_int_base[71:40], entry_int_size[103:72], entry_ext_base[167:104]
	input  logic [167:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// window_hit[0], window_number[7:1], out_address[71:8]
	output logic [71:0]  m_tdata,
	// status[0]
	output logic [0:0]   m_tuser
);
	import awt_pkg::*;

	tok_t              chain [0:NUM_WINDOWS];
	logic              adv;
	cmd_t              in_cmd;
	logic              in_wr;

	logic              out_valid_q;
	logic              status_q;
	logic              hit_q;
	logic [IDX_W-1:0]  num_q;
	logic [EXT_W-1:0]  oaddr_q;

	logic              status_d;
	logic              hit_d;
	logic [IDX_W-1:0]  num_d;
	logic [EXT_W-1:0]  oaddr_d;
	tok_t              last;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign in_cmd   = cmd_t'(s_tuser);
	assign in_wr    = in_cmd == CMD_WRITE;

	always_comb begin
		chain[0].valid = s_tvalid;
		chain[0].cmd   = in_cmd;
		chain[0].a     = in_wr ? s_tdata[71:40] : s_tdata[31:0];
		chain[0].b     = in_wr ? s_tdata[103:72] : '0;
		chain[0].x     = in_wr ? s_tdata[167:104] : '0;
		chain[0].idx   = in_wr ? s_tdata[38:32] : '0;
		chain[0].flag  = in_wr ? s_tdata[39] : 1'b0;
	end

	for (genvar i = 0; i < NUM_WINDOWS; i++) begin : g_cell
		awt_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign last = chain[NUM_WINDOWS];

	always_comb begin
		status_d = 1'b0;
		hit_d    = 1'b0;
		num_d    = '0;
		oaddr_d  = '0;
		case (last.cmd)
			CMD_FORWARD: begin
				if (last.flag) begin
					hit_d   = 1'b1;
					num_d   = last.idx;
					oaddr_d = last.x + {{(EXT_W-ADDR_W){1'b0}}, last.b};
				end else begin
					status_d = 1'b1;
				end
			end
			CMD_RETURN: begin
				if (last.flag) begin
					status_d = 1'b1;
					hit_d    = 1'b1;
					num_d    = last.idx;
				end else begin
					oaddr_d = {{(EXT_W-ADDR_W){1'b0}}, last.a};
				end
			end
			CMD_WRITE: begin
				status_d = 1'b0;
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			hit_q    <= hit_d;
			num_q    <= num_d;
			oaddr_q  <= oaddr_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {oaddr_q, num_q, hit_q};
	assign m_tuser[0] = status_q;

endmodule
